>>> src/merge_sort_buffer_top_assert.svh
// Assertion macros for the merge sort buffer.
`ifndef MERGE_SORT_BUFFER_TOP_ASSERT_SVH
`define MERGE_SORT_BUFFER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define MSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define MSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define MSB_ASSERT(lbl, prop, msg)
`define MSB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/msb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_INIT,
        ST_FETCH,
        ST_WAIT_A,
        ST_WAIT_B,
        ST_PICK,
        ST_OUT,
        ST_DRAIN
    } t_state;

    localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

>>> src/msb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module msb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/merge_sort_buffer_top.sv
// Batch sorter. Values are loaded one item per cycle (busy stays low) until an
// item marked end_of_batch; items beyond MAX_ITEMS are dropped and flagged on
// every result of that batch. The batch of n values is then sorted by bottom-up
// merge passes that ping-pong between two single-port-read RAMs: each element
// of each pass is read into a run head through the registered RAM read, then
// compared and written, with a setup step per run, over ceil(log2(n)) passes.
// The n results then follow back to back on o_valid after the last pass, the
// last one with o_final_result set. The receiver cannot stall: each result is
// on the ports for one cycle only. busy stays high from the end item until the
// last result has gone out.
`timescale 1ns / 1ps
`default_nettype none

`include "merge_sort_buffer_top_assert.svh"

module merge_sort_buffer_top
    import msb_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] i_sample_value,
    input  wire logic                     i_end_of_batch,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_final_result,
    output logic                          o_overflow_flag
);

    localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
    localparam int unsigned W_W    = CNT_W + 1;
    localparam int unsigned SUM_W  = CNT_W + 2;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dropped, n_dropped;
    logic             r_src, n_src;
    logic [W_W-1:0]   r_width, n_width;
    logic [CNT_W-1:0] r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CNT_W-1:0] r_a, n_a, r_b, n_b, r_o, n_o, r_k, n_k;
    logic             r_va, n_va, r_vb, n_vb;
    logic signed [DATA_W-1:0] r_head_a, n_head_a, r_head_b, n_head_b;
    logic             r_pend, n_pend, r_pend_last, n_pend_last;

    // memory ports
    logic              work_we, scr_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data, work_rd, scr_rd;
    logic signed [DATA_W-1:0] src_rd;

    // run bounds
    logic [SUM_W-1:0] lo_ext, w_ext, n_ext, mid_s, hi_s;
    logic [W_W-1:0]   w_dbl;
    logic             need_a, need_b, take_a, run_done, accept;

    msb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (work_rd)
    );

    msb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (scr_rd)
    );

    assign src_rd   = r_src ? $signed(scr_rd) : $signed(work_rd);
    assign lo_ext   = SUM_W'(r_lo);
    assign w_ext    = SUM_W'(r_width);
    assign n_ext    = SUM_W'(r_count);
    assign mid_s    = lo_ext + w_ext;
    assign hi_s     = lo_ext + (w_ext << 1);
    assign w_dbl    = r_width << 1;
    assign need_a   = !r_va && (r_a < r_mid);
    assign need_b   = !r_vb && (r_b < r_hi);
    // left run wins ties; an invalid head means that run is used up
    assign take_a   = r_va && (!r_vb || (r_head_a <= r_head_b));
    assign run_done = (W_W'(r_o) + W_W'(1)) == W_W'(r_hi);
    assign accept   = start && !busy;

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_pend;
    assign o_sorted_value  = src_rd;
    assign o_final_result  = r_pend_last;
    assign o_overflow_flag = r_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_src       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_va        <= n_va;
            r_vb        <= n_vb;
            r_src       <= n_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width  <= n_width;
        r_lo     <= n_lo;
        r_mid    <= n_mid;
        r_hi     <= n_hi;
        r_a      <= n_a;
        r_b      <= n_b;
        r_o      <= n_o;
        r_k      <= n_k;
        r_head_a <= n_head_a;
        r_head_b <= n_head_b;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_src       = r_src;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_a         = r_a;
        n_b         = r_b;
        n_o         = r_o;
        n_k         = r_k;
        n_va        = r_va;
        n_vb        = r_vb;
        n_head_a    = r_head_a;
        n_head_b    = r_head_b;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        work_we     = 1'b0;
        scr_we      = 1'b0;
        wr_addr     = r_o[ADDR_W-1:0];
        wr_data     = take_a ? r_head_a : r_head_b;
        rd_addr     = r_a[ADDR_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                wr_addr = r_count[ADDR_W-1:0];
                wr_data = i_sample_value;
                if (accept) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        work_we = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_end_of_batch) begin
                        n_src   = 1'b0;
                        n_width = W_W'(1);
                        n_lo    = '0;
                        n_k     = '0;
                        // a single value needs no pass
                        if (n_count > CNT_W'(1)) begin
                            n_state = ST_RUN_INIT;
                        end else begin
                            n_state = ST_OUT;
                        end
                    end
                end
            end
            ST_RUN_INIT: begin
                n_mid   = (mid_s > n_ext) ? r_count : mid_s[CNT_W-1:0];
                n_hi    = (hi_s > n_ext) ? r_count : hi_s[CNT_W-1:0];
                n_a     = r_lo;
                n_b     = (mid_s > n_ext) ? r_count : mid_s[CNT_W-1:0];
                n_o     = r_lo;
                n_va    = 1'b0;
                n_vb    = 1'b0;
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                priority if (need_a) begin
                    rd_addr = r_a[ADDR_W-1:0];
                    n_state = ST_WAIT_A;
                end else if (need_b) begin
                    rd_addr = r_b[ADDR_W-1:0];
                    n_state = ST_WAIT_B;
                end else begin
                    n_state = ST_PICK;
                end
            end
            ST_WAIT_A: begin
                n_head_a = src_rd;
                n_va     = 1'b1;
                n_state  = ST_FETCH;
            end
            ST_WAIT_B: begin
                n_head_b = src_rd;
                n_vb     = 1'b1;
                n_state  = ST_FETCH;
            end
            ST_PICK: begin
                if (r_src) begin
                    work_we = 1'b1;
                end else begin
                    scr_we = 1'b1;
                end
                if (take_a) begin
                    n_a  = r_a + CNT_W'(1);
                    n_va = 1'b0;
                end else begin
                    n_b  = r_b + CNT_W'(1);
                    n_vb = 1'b0;
                end
                n_o = r_o + CNT_W'(1);
                if (run_done) begin
                    n_va = 1'b0;
                    n_vb = 1'b0;
                    if (hi_s >= n_ext) begin
                        // pass complete: swap buffers, double the run width
                        n_src   = !r_src;
                        n_width = w_dbl;
                        n_lo    = '0;
                        if (W_W'(r_count) <= w_dbl) begin
                            n_k     = '0;
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_RUN_INIT;
                        end
                    end else begin
                        n_lo    = hi_s[CNT_W-1:0];
                        n_state = ST_RUN_INIT;
                    end
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_OUT: begin
                rd_addr     = r_k[ADDR_W-1:0];
                n_pend      = 1'b1;
                n_pend_last = (W_W'(r_k) + W_W'(1)) == W_W'(r_count);
                n_k         = r_k + CNT_W'(1);
                if (n_pend_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_count   = '0;
                n_dropped = 1'b0;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `MSB_ASSERT(a_valid_busy, o_valid |-> busy, "result strobe while idle")
    `MSB_ASSERT(a_final_valid, o_final_result |-> o_valid, "final mark without result")
    `MSB_ASSERT(a_count_cap, r_count <= CNT_W'(MAX_ITEMS), "item count above capacity")
    `MSB_ASSERT(a_pick_head, (r_state == ST_PICK) |-> (r_va || r_vb),
        "merge step with both runs empty")
    `MSB_ASSERT(a_final_ends, o_final_result |=> (!o_valid && r_count == '0),
        "results continue past final mark")

endmodule

`default_nettype wire

>>> tb/merge_sort_buffer_top_test.sv
`timescale 1ns / 1ps

module merge_sort_buffer_top_test;
    import msb_pkg::*;

    localparam int unsigned MAX_ITEMS = 64;
    localparam int RANDOM_ITEMS = 280;
    localparam int QUIET_AFTER = 230;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 20;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        sample_t value;
        logic    last;
        logic    dropped;
    } sorted_out_t;

    // Tracks the batch being loaded and predicts its sorted output.
    class batch_sort_scoreboard;
        sample_t     loaded[$];
        int unsigned load_count;
        logic        dropped_seen;
        sorted_out_t expected_sorted[$];
        int          mismatches;

        function new();
            load_count = 0;
            dropped_seen = 1'b0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        function void note_sample(sample_t value, logic last);
            sample_t     ordered[$];
            sorted_out_t rec;
            int          pos;
            if (load_count < MAX_ITEMS) begin
                loaded.push_back(value);
                load_count++;
            end else begin
                dropped_seen = 1'b1;
            end
            if (!last)
                return;
            // stable: a new value goes after every held value that is <= it
            foreach (loaded[i]) begin
                pos = ordered.size();
                for (int j = 0; j < ordered.size(); j++) begin
                    if (ordered[j] > loaded[i]) begin
                        pos = j;
                        break;
                    end
                end
                ordered.insert(pos, loaded[i]);
            end
            foreach (ordered[i]) begin
                rec.value = ordered[i];
                rec.last = (i == ordered.size() - 1);
                rec.dropped = dropped_seen;
                expected_sorted.push_back(rec);
            end
            loaded.delete();
            load_count = 0;
            dropped_seen = 1'b0;
        endfunction

        function void check_output(sample_t value, logic last, logic dropped);
            sorted_out_t exp;
            if (expected_sorted.size() == 0) begin
                report($sformatf("unexpected result value=%0d final=%0b ovf=%0b",
                                 value, last, dropped));
                return;
            end
            exp = expected_sorted.pop_front();
            if (exp.value !== value || exp.last !== last || exp.dropped !== dropped)
                report($sformatf("exp value=%0d final=%0b ovf=%0b, got value=%0d final=%0b ovf=%0b",
                                 exp.value, exp.last, exp.dropped, value, last, dropped));
        endfunction

        function int pending();
            return expected_sorted.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    sample_t i_sample_value;
    logic    i_end_of_batch;
    logic    o_valid;
    sample_t o_sorted_value;
    logic    o_final_result;
    logic    o_overflow_flag;

    batch_sort_scoreboard sort_check = new();
    int items_sent;

    merge_sort_buffer_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_value (i_sample_value),
        .i_end_of_batch (i_end_of_batch),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_final_result (o_final_result),
        .o_overflow_flag(o_overflow_flag)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sort_check.check_output(o_sorted_value, o_final_result, o_overflow_flag);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("merge_sort_buffer_top_test failed");
        $finish;
    end

    function automatic sample_t pick_value();
        sample_t v;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            2, 3: v = $signed($urandom_range(0, 8)) - 4;   // small range, many ties
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        start = 1'b0;
        i_sample_value = $urandom;
        i_end_of_batch = 1'($urandom_range(0, 1));
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Holds the item until the block takes it.
    task automatic drive_item(input sample_t value, input logic last);
        @(negedge i_clk);
        start = 1'b1;
        i_sample_value = value;
        i_end_of_batch = last;
        do @(posedge i_clk); while (busy);
        sort_check.note_sample(value, last);
        items_sent++;
    endtask

    task automatic send_value(input sample_t value, input logic last, input bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 4));
        drive_item(value, last);
    endtask

    task automatic send_batch(input int size, input bit quiet);
        for (int k = 0; k < size; k++)
            send_value(pick_value(), k == size - 1, quiet);
    endtask

    initial begin
        int  batch_size;
        int  batch_num;
        bit  quiet;
        start = 1'b0;
        i_sample_value = '0;
        i_end_of_batch = 1'b0;
        i_rst_n = 1'b0;
        items_sent = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-item batch
        send_value(32'sh8000_0000, 1'b1, 1'b0);
        // extremes, unsorted, with ties
        send_value(32'sh7fff_ffff, 1'b0, 1'b0);
        send_value(32'sh8000_0000, 1'b0, 1'b0);
        send_value(0, 1'b0, 1'b0);
        send_value(-1, 1'b0, 1'b0);
        send_value(1, 1'b0, 1'b0);
        send_value(32'sh7fff_ffff, 1'b0, 1'b0);
        send_value(32'sh8000_0000, 1'b0, 1'b0);
        send_value(0, 1'b1, 1'b0);
        // equal pair
        send_value(5, 1'b0, 1'b0);
        send_value(5, 1'b1, 1'b0);
        // reverse order
        send_value(100, 1'b0, 1'b0);
        send_value(50, 1'b0, 1'b0);
        send_value(0, 1'b0, 1'b0);
        send_value(-50, 1'b0, 1'b0);
        send_value(-100, 1'b0, 1'b0);
        send_value(-100, 1'b1, 1'b0);
        send_value(32'sh7fff_ffff, 1'b1, 1'b0);

        batch_num = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = (items_sent >= QUIET_AFTER);
            if (batch_num == 0)
                batch_size = MAX_ITEMS;               // exactly full
            else if (batch_num == 1)
                batch_size = MAX_ITEMS + 2;           // end item itself dropped
            else begin
                case ($urandom_range(0, 19))
                    0: batch_size = MAX_ITEMS;
                    1: batch_size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                    2, 3, 4: batch_size = $urandom_range(9, 32);
                    default: batch_size = $urandom_range(1, 8);
                endcase
            end
            send_batch(batch_size, quiet);
            batch_num++;
        end

        @(negedge i_clk);
        start = 1'b0;
        i_end_of_batch = 1'b0;
        while (sort_check.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sort_check.pending() != 0)
            sort_check.report($sformatf("%0d results never arrived", sort_check.pending()));

        if (sort_check.mismatches == 0) begin
            $display("merge_sort_buffer_top_test passed");
        end else begin
            $display("merge_sort_buffer_top_test failed");
        end
        $finish;
    end

endmodule
